// ===== hdl/bdsr_pkg.sv =====
`timescale 1ns / 1ps

package bdsr_pkg;

    localparam int ADC_W      = 10;
    localparam int GAIN_W     = 4;
    localparam int STEP_W     = 8;
    localparam int DUTY_W     = 16;
    localparam int COUNTS_W   = 11;
    localparam int PCT_W      = 7;
    localparam int SUB_SHIFT  = 5;
    localparam int SUB_STEPS  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;

    localparam int PWM_PERIOD_DEF = 255;

    localparam logic [CFG_IDX_W-1:0] REG_OV_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ABOVE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_BELOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX_ABOVE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX_BELOW = 3'd5;

    localparam logic [ADC_W-1:0]  OV_LIMIT_RST  = 10'd787;
    localparam logic [ADC_W-1:0]  SETPOINT_RST  = 10'd721;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MAX_RST  = 8'd1;

    typedef struct packed {
        logic [ADC_W-1:0]  ov_limit;
        logic [ADC_W-1:0]  setpoint;
        logic [GAIN_W-1:0] gain_above;
        logic [GAIN_W-1:0] gain_below;
        logic [STEP_W-1:0] step_max_above;
        logic [STEP_W-1:0] step_max_below;
    } cfg_t;

    typedef struct packed {
        logic              pwm_enabled;
        logic [DUTY_W-1:0] duty;
        logic              ov_active;
    } duty_state_t;

endpackage

// ===== hdl/bdsr_cfg.sv =====
`timescale 1ns / 1ps

module bdsr_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bdsr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bdsr_pkg::cfg_t                      cfg
);

    bdsr_pkg::cfg_t cfg_reg;
    bdsr_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bdsr_pkg::REG_OV_LIMIT:
                    cfg_next.ov_limit = cfg_data[bdsr_pkg::ADC_W-1:0];
                bdsr_pkg::REG_SETPOINT:
                    cfg_next.setpoint = cfg_data[bdsr_pkg::ADC_W-1:0];
                bdsr_pkg::REG_GAIN_ABOVE:
                    cfg_next.gain_above = cfg_data[bdsr_pkg::GAIN_W-1:0];
                bdsr_pkg::REG_GAIN_BELOW:
                    cfg_next.gain_below = cfg_data[bdsr_pkg::GAIN_W-1:0];
                bdsr_pkg::REG_STEP_MAX_ABOVE:
                    cfg_next.step_max_above = cfg_data[bdsr_pkg::STEP_W-1:0];
                bdsr_pkg::REG_STEP_MAX_BELOW:
                    cfg_next.step_max_below = cfg_data[bdsr_pkg::STEP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ov_limit       <= bdsr_pkg::OV_LIMIT_RST;
            cfg_reg.setpoint       <= bdsr_pkg::SETPOINT_RST;
            cfg_reg.gain_above     <= bdsr_pkg::GAIN_RST;
            cfg_reg.gain_below     <= bdsr_pkg::GAIN_RST;
            cfg_reg.step_max_above <= bdsr_pkg::STEP_MAX_RST;
            cfg_reg.step_max_below <= bdsr_pkg::STEP_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/bdsr_update.sv =====
`timescale 1ns / 1ps

module bdsr_update
#(
    parameter int PWM_PERIOD = bdsr_pkg::PWM_PERIOD_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  bdsr_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bdsr_pkg::ADC_W-1:0]      adc_sample,
    output logic                            res_valid,
    input  logic                            res_ready,
    output bdsr_pkg::duty_state_t           res
);

    localparam int FULL_SCALE = PWM_PERIOD * 4 * bdsr_pkg::SUB_STEPS;
    localparam int DUTY_RST_I = (FULL_SCALE * 4) / 5;
    localparam logic [bdsr_pkg::DUTY_W-1:0] DUTY_RST  = DUTY_RST_I[bdsr_pkg::DUTY_W-1:0];
    localparam logic [bdsr_pkg::DUTY_W:0]   FULL_SC_W = FULL_SCALE[bdsr_pkg::DUTY_W:0];
    localparam int PROD_W = bdsr_pkg::ADC_W + bdsr_pkg::GAIN_W;

    logic                            in_valid_reg;
    logic [bdsr_pkg::ADC_W-1:0]      adc_reg;
    logic [bdsr_pkg::DUTY_W-1:0]     duty_reg;
    logic [bdsr_pkg::DUTY_W-1:0]     duty_next;
    logic                            flag_reg;
    logic                            flag_next;
    logic                            res_valid_reg;
    bdsr_pkg::duty_state_t           res_reg;

    logic                            load_res;
    logic                            load_in;
    logic                            above_limit;
    logic                            above_set;
    logic                            below_set;
    logic [bdsr_pkg::ADC_W-1:0]      err_up;
    logic [bdsr_pkg::ADC_W-1:0]      err_dn;
    logic [PROD_W-1:0]               prod_up;
    logic [PROD_W-1:0]               prod_dn;
    logic [bdsr_pkg::STEP_W-1:0]     step_up;
    logic [bdsr_pkg::STEP_W-1:0]     step_dn;
    logic [bdsr_pkg::DUTY_W:0]       duty_sum;

    assign load_res  = !res_valid_reg || res_ready;
    assign load_in   = !in_valid_reg || load_res;
    assign in_ready  = load_in;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign above_limit = adc_reg > cfg.ov_limit;
    assign above_set   = adc_reg > cfg.setpoint;
    assign below_set   = adc_reg < cfg.setpoint;
    assign err_dn      = adc_reg - cfg.setpoint;
    assign err_up      = cfg.setpoint - adc_reg;
    assign prod_dn     = err_dn * cfg.gain_above;
    assign prod_up     = err_up * cfg.gain_below;
    assign step_dn     = (prod_dn > PROD_W'(cfg.step_max_above)) ? cfg.step_max_above
                                                                   : prod_dn[bdsr_pkg::STEP_W-1:0];
    assign step_up     = (prod_up > PROD_W'(cfg.step_max_below)) ? cfg.step_max_below
                                                                   : prod_up[bdsr_pkg::STEP_W-1:0];
    assign duty_sum    = {1'b0, duty_reg} + (bdsr_pkg::DUTY_W + 1)'(step_up);

    always_comb
    begin
        duty_next = duty_reg;
        flag_next = flag_reg;
        if (above_limit)
        begin
            flag_next = 1'b1;
        end
        else if (flag_reg)
        begin
            if (!above_set)
            begin
                duty_next = duty_reg >> 1;
                flag_next = 1'b0;
            end
        end
        else if (above_set)
        begin
            if (bdsr_pkg::DUTY_W'(step_dn) <= duty_reg)
            begin
                duty_next = duty_reg - bdsr_pkg::DUTY_W'(step_dn);
            end
        end
        else if (below_set)
        begin
            if (duty_sum < FULL_SC_W)
            begin
                duty_next = duty_sum[bdsr_pkg::DUTY_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            duty_reg      <= DUTY_RST;
            flag_reg      <= 1'b0;
        end
        else
        begin
            if (load_in)
            begin
                in_valid_reg <= in_valid;
            end
            if (load_res)
            begin
                res_valid_reg <= in_valid_reg;
            end
            if (in_valid_reg && load_res)
            begin
                duty_reg <= duty_next;
                flag_reg <= flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in && in_valid)
        begin
            adc_reg <= adc_sample;
        end
        if (load_res && in_valid_reg)
        begin
            res_reg.pwm_enabled <= !flag_next;
            res_reg.duty        <= duty_next;
            res_reg.ov_active   <= flag_next;
        end
    end

endmodule

// ===== hdl/bdsr_out.sv =====
`timescale 1ns / 1ps

module bdsr_out
#(
    parameter int PWM_PERIOD = bdsr_pkg::PWM_PERIOD_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                res_valid,
    output logic                                res_ready,
    input  bdsr_pkg::duty_state_t               res,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bdsr_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int FULL_SCALE = PWM_PERIOD * 4 * bdsr_pkg::SUB_STEPS;
    localparam int PER_CENT   = (FULL_SCALE / 100 == 0) ? 1 : FULL_SCALE / 100;
    localparam int SHIFT_K    = bdsr_pkg::DUTY_W + $clog2(PER_CENT);
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT_K) + longint'(PER_CENT) - 64'd1) / longint'(PER_CENT);
    localparam int RECIP_W = bdsr_pkg::DUTY_W + 1;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_L[RECIP_W-1:0];
    localparam int PROD_W  = bdsr_pkg::DUTY_W + RECIP_W;
    localparam int FIELD_W = 2 + bdsr_pkg::COUNTS_W + bdsr_pkg::PCT_W;

    logic                                   m_tvalid_reg;
    logic [bdsr_pkg::M_TDATA_W-1:0]         m_tdata_reg;
    logic [PROD_W-1:0]                      prod;
    logic [PROD_W-1:0]                      quot;
    logic [bdsr_pkg::COUNTS_W-1:0]          counts;
    logic [FIELD_W-1:0]                     fields;

    assign res_ready = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign prod   = PROD_W'(res.duty) * PROD_W'(RECIP_M);
    assign quot   = prod >> SHIFT_K;
    assign counts = res.duty[bdsr_pkg::DUTY_W-1:bdsr_pkg::SUB_SHIFT];
    assign fields = {res.ov_active, quot[bdsr_pkg::PCT_W-1:0], counts, res.pwm_enabled};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_tdata_reg <= bdsr_pkg::M_TDATA_W'(fields);
        end
    end

endmodule

// ===== hdl/boost_duty_step_regulator.sv =====
`timescale 1ns / 1ps
// Boost converter duty regulator with overvoltage shutdown.
// Input stream: one 10-bit ADC code of the output voltage per beat on s_tdata.
// Output stream: one beat per input beat with PWM enable, duty in PWM counts,
// duty in whole percent and the overvoltage flag, computed after the update.
// Configuration: write register index on cfg_index and value on cfg_data with
// cfg_valid; cfg_ready is always high. Write only while no beat is in flight.
// Pipeline: input register, duty update register, output register holding the
// percent product.
// Throughput: one beat per cycle while m_tready stays high; the duty
// read-modify-write closes around the duty register.
// Reset: duty returns to 80 percent of full scale, flag clears, registers take
// their default values, the pipeline empties.
// Stall: a low m_tready holds the output beat; the two inner stages keep
// filling, then s_tready drops until the output beat is taken.

module boost_duty_step_regulator
#(
    parameter int PWM_PERIOD = bdsr_pkg::PWM_PERIOD_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bdsr_pkg::S_TDATA_W-1:0]      s_tdata,  // [9:0] adc_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] pwm_enabled, [11:1] duty_counts, [18:12] duty_percent, [19] overvoltage_active
    output logic [bdsr_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bdsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    bdsr_pkg::cfg_t         cfg;
    bdsr_pkg::duty_state_t  res;
    logic                   res_valid;
    logic                   res_ready;

    bdsr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bdsr_update #(.PWM_PERIOD(PWM_PERIOD)) u_update
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .adc_sample (s_tdata[bdsr_pkg::ADC_W-1:0]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    bdsr_out #(.PWM_PERIOD(PWM_PERIOD)) u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== hdl/bdsr_checker.sv =====
`timescale 1ns / 1ps

module bdsr_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [bdsr_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int OV_BIT = 1 + bdsr_pkg::COUNTS_W + bdsr_pkg::PCT_W;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_enable_vs_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[0] != m_tdata[OV_BIT])
        else $error("pwm enable and overvoltage flag disagree");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind boost_duty_step_regulator bdsr_checker u_bdsr_checker (.*);
